// ----- hw/rtl/imurd_pkg.sv -----
package imurd_pkg;

  typedef enum logic [0:0] {
    CfgAccelRange = 1'b0,
    CfgGyroRange  = 1'b1
  } cfg_idx_e;

  // Fixed divisors: gyro divisors per full-scale range (times ten) and the ms-to-s thousand
  typedef enum logic [2:0] {
    KdGyro250,
    KdGyro500,
    KdGyro1000,
    KdGyro2000,
    KdMilli
  } kdiv_e;

  function automatic logic [11:0] kdiv_den(input kdiv_e k);
    case (k)
      KdGyro250:  return 12'd2620;
      KdGyro500:  return 12'd1310;
      KdGyro1000: return 12'd656;
      KdGyro2000: return 12'd328;
      default:    return 12'd1000;
    endcase
  endfunction

  // Reciprocal shift: 28-bit partial dividend plus ceil(log2(divisor))
  function automatic logic [5:0] kdiv_shift(input kdiv_e k);
    case (k)
      KdGyro250:  return 6'd40;
      KdGyro500:  return 6'd39;
      KdGyro1000: return 6'd38;
      KdGyro2000: return 6'd37;
      default:    return 6'd38;
    endcase
  endfunction

  // Rounded-up reciprocal, exact for partial dividends below 2^28
  function automatic logic [28:0] kdiv_mul(input kdiv_e k);
    case (k)
      KdGyro250:  return 29'(((64'd1 << 40) + 64'd2619) / 64'd2620);
      KdGyro500:  return 29'(((64'd1 << 39) + 64'd1309) / 64'd1310);
      KdGyro1000: return 29'(((64'd1 << 38) + 64'd655) / 64'd656);
      KdGyro2000: return 29'(((64'd1 << 37) + 64'd327) / 64'd328);
      default:    return 29'(((64'd1 << 38) + 64'd999) / 64'd1000);
    endcase
  endfunction

  // Datapath operations issued by the controller
  typedef enum logic [2:0] {
    OpNone,
    OpLoad,
    OpScale,
    OpAlpha,
    OpVel,
    OpPos,
    OpCommit
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] axis;
    logic       start;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_sts_t;

endpackage

// ----- hw/rtl/imurd_if.sv -----
interface imurd_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] gyro_x;
  logic signed [15:0] gyro_y;
  logic signed [15:0] gyro_z;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic        [31:0] timestamp_ms;
  modport source (output valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
                  timestamp_ms, input ready);
  modport sink (input valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
                timestamp_ms, output ready);
endinterface

interface imurd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] alpha_x;
  logic signed [31:0] alpha_y;
  logic signed [31:0] alpha_z;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic               dt_zero;
  modport source (output valid, alpha_x, alpha_y, alpha_z, vel_x, vel_y, vel_z,
                  pos_x, pos_y, pos_z, dt_zero, input ready);
  modport sink (input valid, alpha_x, alpha_y, alpha_z, vel_x, vel_y, vel_z,
                pos_x, pos_y, pos_z, dt_zero, output ready);
endinterface

// ----- hw/rtl/imurd_div.sv -----
// Restoring divider, one quotient bit a cycle, signed truncating
module imurd_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] num_i,
  input  logic        [31:0] den_i,
  output logic               done_o,
  output logic signed [63:0] quo_o
);
  logic [63:0] mag_q, mag_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] den_q;
  logic        neg_q;
  logic [6:0]  cnt_q;
  logic        busy_q;
  logic [32:0] trial;

  always_comb begin
    trial = {rem_q[31:0], mag_q[63]} - {1'b0, den_q};
    rem_d = {rem_q[31:0], mag_q[63]};
    mag_d = {mag_q[62:0], 1'b0};
    if (!trial[32]) begin
      rem_d    = trial;
      mag_d[0] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 7'd0;
        neg_q  <= num_i[63];
        mag_q  <= num_i[63] ? 64'(-num_i) : 64'(num_i);
        rem_q  <= '0;
        den_q  <= den_i;
      end else if (busy_q) begin
        mag_q <= mag_d;
        rem_q <= rem_d;
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == 7'd63) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  assign quo_o = neg_q ? -$signed(mag_q) : $signed(mag_q);
endmodule

// Division by a fixed divisor, sixteen quotient bits per digit: a
// reciprocal multiply gives each digit, the next cycle forms the remainder.
// The quotient is ready when done_o pulses, signed truncating.
module imurd_cdiv
  import imurd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] num_i,
  input  kdiv_e              sel_i,
  output logic               done_o,
  output logic signed [63:0] quo_o
);
  logic [63:0] num_q, quo_q;
  logic [11:0] rem_q;
  logic [15:0] dig_q;
  logic [1:0]  cnt_q;
  logic        busy_q, phase_q, neg_q;
  kdiv_e       sel_q;
  logic [27:0] part;
  logic [56:0] recip;
  logic [15:0] dig;
  logic [27:0] back;

  // Partial dividend: remainder so far and the next sixteen bits
  assign part  = {rem_q, num_q[63:48]};
  assign recip = 57'(part) * 57'(kdiv_mul(sel_q));
  assign dig   = 16'(recip >> kdiv_shift(sel_q));
  assign back  = part - 28'(dig_q) * 28'(kdiv_den(sel_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
      cnt_q   <= '0;
      done_o  <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        phase_q <= 1'b0;
        cnt_q   <= 2'd0;
        neg_q   <= num_i[63];
        num_q   <= num_i[63] ? 64'(-num_i) : 64'(num_i);
        quo_q   <= '0;
        rem_q   <= '0;
        sel_q   <= sel_i;
      end else if (busy_q) begin
        if (!phase_q) begin
          dig_q   <= dig;
          phase_q <= 1'b1;
        end else begin
          phase_q <= 1'b0;
          rem_q   <= back[11:0];
          quo_q   <= {quo_q[47:0], dig_q};
          num_q   <= {num_q[47:0], 16'h0000};
          cnt_q   <= cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            busy_q <= 1'b0;
            done_o <= 1'b1;
          end
        end
      end
    end
  end

  assign quo_o = neg_q ? -$signed(quo_q) : $signed(quo_q);
endmodule

// ----- hw/rtl/imurd_datapath.sv -----
module imurd_datapath
  import imurd_pkg::*;
#(
  parameter int unsigned FracBits = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  output dp_sts_t            sts_o,
  input  logic [1:0]         accel_range_i,
  input  logic [1:0]         gyro_range_i,
  input  logic signed [15:0] gyro_i  [3],
  input  logic signed [15:0] accel_i [3],
  input  logic        [31:0] time_i,
  output logic signed [31:0] alpha_o [3],
  output logic signed [31:0] vel_o   [3],
  output logic signed [31:0] pos_o   [3],
  output logic               dt_zero_o
);
  localparam logic signed [63:0] Max32 = 64'sd2147483647;
  localparam logic signed [63:0] Min32 = -64'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > Max32) return 32'sh7fffffff;
    if (v < Min32) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Accelerometer divisors are ten times a power of two: a shift suffices
  function automatic logic signed [31:0] accel_scale(input logic signed [15:0] c,
                                                     input logic [1:0] r);
    logic signed [16:0] cx;
    logic        [16:0] a;
    logic        [63:0] q;
    cx = 17'(c);
    a  = cx[16] ? 17'(-cx) : 17'(cx);
    q  = (64'(a) << FracBits) >> (4'd14 - 4'(r));
    return sat32(cx[16] ? -$signed(q) : $signed(q));
  endfunction

  logic        [31:0] last_q, dt_q;
  logic signed [31:0] prev_q [3];
  logic signed [31:0] vel_q  [3];
  logic signed [31:0] pos_q  [3];
  logic signed [31:0] rate_q [3];
  logic signed [31:0] acc_q  [3];
  logic signed [15:0] gyro_q [3];
  logic        [31:0] now_q;
  logic signed [31:0] alpha_q[3];

  logic               vdiv_start, cdiv_start;
  logic signed [63:0] vdiv_num, vdiv_quo;
  logic signed [63:0] cdiv_num, cdiv_quo;
  logic               vdiv_done, cdiv_done;
  kdiv_e              cdiv_sel;
  logic signed [31:0] mul_a;
  logic signed [63:0] prod;
  logic [1:0]         ax;

  assign ax = cmd_i.axis;

  // Divider operand selection; one multiplier serves both increments
  always_comb begin
    vdiv_num = '0;
    cdiv_num = '0;
    cdiv_sel = KdMilli;
    mul_a    = (cmd_i.op == OpPos) ? vel_q[ax] : acc_q[ax];
    prod     = mul_a * $signed({1'b0, dt_q});
    case (cmd_i.op)
      OpScale: begin
        cdiv_num = (64'(gyro_q[ax]) * 64'sd10) <<< FracBits;
        case (gyro_range_i)
          2'd0:    cdiv_sel = KdGyro250;
          2'd1:    cdiv_sel = KdGyro500;
          2'd2:    cdiv_sel = KdGyro1000;
          default: cdiv_sel = KdGyro2000;
        endcase
      end
      OpAlpha: vdiv_num = 64'(rate_q[ax]) - 64'(prev_q[ax]);
      OpVel:   cdiv_num = prod;
      OpPos:   cdiv_num = prod;
      default: ;
    endcase
  end

  assign vdiv_start = cmd_i.start && (cmd_i.op == OpAlpha);
  assign cdiv_start = cmd_i.start && (cmd_i.op != OpAlpha);

  imurd_div u_div (
    .clk_i, .rst_ni, .start_i(vdiv_start), .num_i(vdiv_num), .den_i(dt_q),
    .done_o(vdiv_done), .quo_o(vdiv_quo)
  );

  imurd_cdiv u_cdiv (
    .clk_i, .rst_ni, .start_i(cdiv_start), .num_i(cdiv_num), .sel_i(cdiv_sel),
    .done_o(cdiv_done), .quo_o(cdiv_quo)
  );

  assign sts_o.div_done = vdiv_done | cdiv_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      for (int i = 0; i < 3; i++) begin
        prev_q[i] <= '0;
        vel_q[i]  <= '0;
        pos_q[i]  <= '0;
      end
    end else begin
      case (cmd_i.op)
        OpLoad: begin
          gyro_q <= gyro_i;
          now_q  <= time_i;
          dt_q   <= time_i - last_q;
          for (int i = 0; i < 3; i++) acc_q[i] <= accel_scale(accel_i[i], accel_range_i);
        end
        OpScale: if (cdiv_done) rate_q[ax] <= sat32(cdiv_quo);
        OpAlpha: if (vdiv_done) alpha_q[ax] <= (dt_q == '0) ? '0 : sat32(vdiv_quo);
        OpVel: if (cdiv_done) vel_q[ax] <= sat32(64'(vel_q[ax]) + cdiv_quo);
        OpPos: if (cdiv_done) pos_q[ax] <= sat32(64'(pos_q[ax]) + cdiv_quo);
        OpCommit: begin
          last_q <= now_q;
          prev_q <= rate_q;
        end
        default: ;
      endcase
    end
  end

  assign alpha_o   = alpha_q;
  assign vel_o     = vel_q;
  assign pos_o     = pos_q;
  assign dt_zero_o = (dt_q == '0);
endmodule

// ----- hw/rtl/imurd_ctrl.sv -----
module imurd_ctrl
  import imurd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o,
  input  dp_sts_t sts_i
);
  typedef enum logic [2:0] {
    StIdle, StLoad, StRun, StWait, StCommit, StOut
  } state_e;

  state_e     state_q;
  dp_op_e     op_q;
  logic [1:0] axis_q;
  logic [2:0] pass_q;

  // The sample is latched at the accepting edge
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign cmd_o.op    = (state_q == StIdle && in_valid_i) ? OpLoad :
                       (state_q == StCommit) ? OpCommit :
                       (state_q == StRun || state_q == StWait) ? op_q : OpNone;
  assign cmd_o.axis  = axis_q;
  assign cmd_o.start = (state_q == StRun);

  // Sequence: gyro scale x3, then alpha x3, vel x3, pos x3 over the axes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      op_q    <= OpNone;
      axis_q  <= '0;
      pass_q  <= '0;
    end else begin
      case (state_q)
        StIdle: if (in_valid_i) state_q <= StLoad;
        StLoad: begin
          state_q <= StRun;
          op_q    <= OpScale;
          axis_q  <= '0;
          pass_q  <= '0;
        end
        StRun: state_q <= StWait;
        StWait: if (sts_i.div_done) begin
          state_q <= StRun;
          if (axis_q != 2'd2) axis_q <= axis_q + 2'd1;
          else begin
            axis_q <= '0;
            pass_q <= pass_q + 3'd1;
            case (pass_q)
              3'd0:    op_q <= OpAlpha;
              3'd1:    op_q <= OpVel;
              3'd2:    op_q <= OpPos;
              default: state_q <= StCommit;
            endcase
          end
        end
        StCommit: state_q <= StOut;
        StOut: if (out_ready_i) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

// ----- hw/rtl/imu_rate_derivative_and_integration_unit.sv -----
// One IMU sample at a time: the sample is latched at the accepting edge and
// the accelerometer counts are scaled there by shifts. Twelve divisions then
// run one after another: three gyro scalings and six velocity/position
// increments on a fixed-divisor unit, and three rate derivatives on a
// 64-bit restoring divider by the time step. The result beat is presented
// after the last division has been committed and is held until taken; the
// next sample is accepted only after that.
module imu_rate_derivative_and_integration_unit
  import imurd_pkg::*;
#(
  parameter int unsigned FracBits = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [1:0]  cfg_data_i,
  imurd_in_if.sink    in_if,
  imurd_out_if.source out_if
);
  logic [1:0] accel_range_q, gyro_range_q;
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic signed [15:0] gyro [3];
  logic signed [15:0] accel[3];
  logic signed [31:0] alpha[3], vel[3], pos[3];

  // Range registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_range_q <= '0;
      gyro_range_q  <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgAccelRange) accel_range_q <= cfg_data_i;
      else                            gyro_range_q  <= cfg_data_i;
    end
  end

  assign gyro  = '{in_if.gyro_x, in_if.gyro_y, in_if.gyro_z};
  assign accel = '{in_if.accel_x, in_if.accel_y, in_if.accel_z};

  imurd_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready), .cmd_o(cmd), .sts_i(sts)
  );

  imurd_datapath #(.FracBits(FracBits)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .accel_range_i(accel_range_q),
    .gyro_range_i(gyro_range_q), .gyro_i(gyro), .accel_i(accel),
    .time_i(in_if.timestamp_ms), .alpha_o(alpha), .vel_o(vel), .pos_o(pos),
    .dt_zero_o(out_if.dt_zero)
  );

  assign out_if.alpha_x = alpha[0];
  assign out_if.alpha_y = alpha[1];
  assign out_if.alpha_z = alpha[2];
  assign out_if.vel_x   = vel[0];
  assign out_if.vel_y   = vel[1];
  assign out_if.vel_z   = vel[2];
  assign out_if.pos_x   = pos[0];
  assign out_if.pos_y   = pos[1];
  assign out_if.pos_z   = pos[2];
endmodule

// ----- hw/rtl/imurd_checker.sv -----
module imurd_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic dt_zero
);
  // No new sample while a result beat waits
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready) else $error("accept while result pending");
  // Result held until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(dt_zero))
    else $error("result dropped");
  // Accept is never followed at once by a result
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !out_valid) else $error("result too early");
endmodule

bind imu_rate_derivative_and_integration_unit imurd_checker u_chk (
  .clk_i, .rst_ni, .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready), .dt_zero(out_if.dt_zero)
);

// ----- tb/tb_imu_rate_derivative_and_integration_unit.sv -----
module tb_imu_rate_derivative_and_integration_unit;
  import imurd_pkg::*;

  localparam int unsigned CycleLimit = 12_000_000;
  localparam int unsigned RandomItems = 1500;

  typedef struct {
    logic signed [15:0] gyro [3];
    logic signed [15:0] accel [3];
    logic        [31:0] stamp;
  } imu_sample_t;

  typedef struct {
    logic signed [31:0] alpha [3];
    logic signed [31:0] vel [3];
    logic signed [31:0] pos [3];
    logic               dt_zero;
  } nav_result_t;

  // Full-scale divisors, times ten
  localparam longint AccelDiv10 [4] = '{163840, 81920, 40960, 20480};
  localparam longint GyroDiv10 [4]  = '{2620, 1310, 656, 328};

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [0:0] cfg_idx_i;
  logic [1:0] cfg_data_i;

  imurd_in_if  in_bus ();
  imurd_out_if out_bus ();

  imu_rate_derivative_and_integration_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_bus),
    .out_if     (out_bus)
  );

  imu_sample_t samples_to_send [$];
  nav_result_t expected_nav [$];
  int unsigned errors;
  int unsigned cycle_cnt;
  bit          long_hold_req;

  // Shadow of the block's registers and state
  logic [1:0]         sh_accel_range;
  logic [1:0]         sh_gyro_range;
  logic [31:0]        sh_last_time;
  logic signed [31:0] sh_prev_rate [3];
  logic signed [31:0] sh_vel [3];
  logic signed [31:0] sh_pos [3];

  // Stimulus generator state
  logic [31:0] gen_stamp;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] to_q16(logic signed [15:0] cnt, longint div10);
    longint num;
    num = longint'(cnt) * 10 * 65536;
    return clamp32(num / div10);
  endfunction

  // Works out one result and advances the shadow state
  task automatic integrate_sample(input imu_sample_t s);
    nav_result_t r;
    logic [31:0] dt;
    longint      dt64;
    logic signed [31:0] rate, acc;
    dt = s.stamp - sh_last_time;
    dt64 = longint'(dt);
    r.dt_zero = (dt == 32'd0);
    for (int i = 0; i < 3; i++) begin
      rate = to_q16(s.gyro[i], GyroDiv10[sh_gyro_range]);
      acc = to_q16(s.accel[i], AccelDiv10[sh_accel_range]);
      r.alpha[i] = r.dt_zero ? 32'sd0 :
                   clamp32((longint'(rate) - longint'(sh_prev_rate[i])) / dt64);
      sh_vel[i] = clamp32(longint'(sh_vel[i]) + (longint'(acc) * dt64) / 1000);
      sh_pos[i] = clamp32(longint'(sh_pos[i]) + (longint'(sh_vel[i]) * dt64) / 1000);
      sh_prev_rate[i] = rate;
      r.vel[i] = sh_vel[i];
      r.pos[i] = sh_pos[i];
    end
    sh_last_time = s.stamp;
    expected_nav.push_back(r);
  endtask

  // Sample driver
  imu_sample_t drv_item;
  int unsigned drv_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
      drv_gap = 0;
    end else begin
      if (in_bus.valid && in_bus.ready) integrate_sample(drv_item);
      if (in_bus.valid && !in_bus.ready) begin
        // hold the beat
      end else if (drv_gap > 0) begin
        drv_gap--;
        in_bus.valid <= 1'b0;
      end else if (samples_to_send.size() > 0) begin
        drv_item = samples_to_send.pop_front();
        in_bus.gyro_x <= drv_item.gyro[0];
        in_bus.gyro_y <= drv_item.gyro[1];
        in_bus.gyro_z <= drv_item.gyro[2];
        in_bus.accel_x <= drv_item.accel[0];
        in_bus.accel_y <= drv_item.accel[1];
        in_bus.accel_z <= drv_item.accel[2];
        in_bus.timestamp_ms <= drv_item.stamp;
        in_bus.valid <= 1'b1;
        case ($urandom_range(0, 99)) inside
          [0:59]:  drv_gap = 0;
          [60:94]: drv_gap = $urandom_range(1, 5);
          default: drv_gap = $urandom_range(50, 1500);
        endcase
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Result monitor and checker
  int unsigned sink_stall;
  always @(posedge clk_i or negedge rst_ni) begin
    nav_result_t e;
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_nav.size() == 0) begin
          $display("%0t: unexpected result beat", $time);
          errors++;
        end else begin
          e = expected_nav.pop_front();
          if (e.alpha[0] !== out_bus.alpha_x || e.alpha[1] !== out_bus.alpha_y ||
              e.alpha[2] !== out_bus.alpha_z || e.vel[0] !== out_bus.vel_x ||
              e.vel[1] !== out_bus.vel_y || e.vel[2] !== out_bus.vel_z ||
              e.pos[0] !== out_bus.pos_x || e.pos[1] !== out_bus.pos_y ||
              e.pos[2] !== out_bus.pos_z || e.dt_zero !== out_bus.dt_zero) begin
            $display("%0t: mismatch exp alpha %0d %0d %0d vel %0d %0d %0d pos %0d %0d %0d dtz %0b",
                     $time, e.alpha[0], e.alpha[1], e.alpha[2], e.vel[0], e.vel[1],
                     e.vel[2], e.pos[0], e.pos[1], e.pos[2], e.dt_zero);
            $display("%0t:          act alpha %0d %0d %0d vel %0d %0d %0d pos %0d %0d %0d dtz %0b",
                     $time, out_bus.alpha_x, out_bus.alpha_y, out_bus.alpha_z,
                     out_bus.vel_x, out_bus.vel_y, out_bus.vel_z, out_bus.pos_x,
                     out_bus.pos_y, out_bus.pos_z, out_bus.dt_zero);
            errors++;
          end
        end
      end
      if (sink_stall > 0) begin
        sink_stall--;
        out_bus.ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        sink_stall = 4000;
        out_bus.ready <= 1'b0;
      end else begin
        case ($urandom_range(0, 99)) inside
          [0:69]:  out_bus.ready <= 1'b1;
          [70:96]: begin
            sink_stall = $urandom_range(1, 4);
            out_bus.ready <= 1'b0;
          end
          default: begin
            sink_stall = $urandom_range(20, 400);
            out_bus.ready <= 1'b0;
          end
        endcase
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("[imu_rate_derivative_and_integration_unit] ERROR");
      $finish;
    end
  end

  function automatic logic signed [15:0] rand_count();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      default: return 16'($urandom());
    endcase
  endfunction

  // Queue one sample; stamp steps by dt from the running time
  task automatic add_sample(input logic signed [15:0] g, input logic signed [15:0] a,
                            input logic [31:0] dt, input bit mixed);
    imu_sample_t s;
    for (int i = 0; i < 3; i++) begin
      s.gyro[i] = mixed ? rand_count() : g;
      s.accel[i] = mixed ? rand_count() : a;
    end
    gen_stamp = gen_stamp + dt;
    s.stamp = gen_stamp;
    samples_to_send.push_back(s);
  endtask

  task automatic add_random_sample();
    logic [31:0] dt;
    case ($urandom_range(0, 99)) inside
      [0:9]:   dt = 32'd0;
      [10:84]: dt = $urandom_range(1, 20);
      [85:94]: dt = $urandom_range(21, 100000);
      default: dt = $urandom();
    endcase
    add_sample(16'sd0, 16'sd0, dt, 1'b1);
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (samples_to_send.size() > 0 || expected_nav.size() > 0 || in_bus.valid);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgAccelRange) sh_accel_range = val;
    else sh_gyro_range = val;
    @(posedge clk_i);
  endtask

  initial begin
    errors = 0;
    cycle_cnt = 0;
    long_hold_req = 1'b0;
    gen_stamp = 32'd0;
    sh_accel_range = 2'd0;
    sh_gyro_range = 2'd0;
    sh_last_time = 32'd0;
    for (int i = 0; i < 3; i++) begin
      sh_prev_rate[i] = 32'sd0;
      sh_vel[i] = 32'sd0;
      sh_pos[i] = 32'sd0;
    end
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgAccelRange;
    cfg_data_i = 2'd0;
    in_bus.valid = 1'b0;
    in_bus.gyro_x = '0;
    in_bus.gyro_y = '0;
    in_bus.gyro_z = '0;
    in_bus.accel_x = '0;
    in_bus.accel_y = '0;
    in_bus.accel_z = '0;
    in_bus.timestamp_ms = '0;
    out_bus.ready = 1'b0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: first sample at time zero gives a zero step
    add_sample(16'sh7fff, 16'sh7fff, 32'd0, 1'b0);
    add_sample(16'sh8000, 16'sh8000, 32'd1, 1'b0);
    add_sample(16'sh7fff, 16'sh7fff, 32'd1, 1'b0);
    add_sample(16'sh0000, 16'sh0000, 32'd0, 1'b0);
    add_sample(16'sh7fff, 16'sh7fff, 32'd4000000, 1'b0);
    add_sample(16'sh8000, 16'sh8000, 32'hfff00000, 1'b0);
    add_sample(16'sh8000, 16'sh8000, 32'hffffffff, 1'b0);
    add_sample(16'sh0001, 16'shffff, 32'd3, 1'b0);
    // Receiver holds off while samples keep coming
    long_hold_req = 1'b1;
    wait_idle();

    // Range extremes; prev rate keeps its old scaling across the change
    write_reg(CfgAccelRange, 2'd3);
    write_reg(CfgGyroRange, 2'd3);
    add_sample(16'sh7fff, 16'sh8000, 32'd1, 1'b0);
    add_sample(16'sh8000, 16'sh7fff, 32'd7, 1'b0);
    add_sample(16'sh1234, 16'shedcb, 32'd0, 1'b0);
    add_sample(16'sh0000, 16'sh0000, 32'd1000, 1'b0);
    wait_idle();
    write_reg(CfgGyroRange, 2'd1);
    write_reg(CfgAccelRange, 2'd2);
    add_sample(16'sh4000, 16'shc000, 32'd2, 1'b0);
    add_sample(16'shc000, 16'sh4000, 32'd2, 1'b0);
    wait_idle();

    // Random phases under a range setting each
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CfgAccelRange, (ph == 0) ? 2'd0 : (ph == 1) ? 2'd3 : 2'($urandom()));
      write_reg(CfgGyroRange, (ph == 0) ? 2'd3 : (ph == 1) ? 2'd0 : 2'($urandom()));
      for (int n = 0; n < RandomItems / 5; n++) add_random_sample();
      if (ph == 2) long_hold_req = 1'b1;
      wait_idle();
    end

    repeat (20) @(posedge clk_i);
    if (errors == 0 && expected_nav.size() == 0)
      $display("[imu_rate_derivative_and_integration_unit] OK");
    else
      $display("[imu_rate_derivative_and_integration_unit] ERROR");
    $finish;
  end

endmodule

// ----- imu_rate_derivative_and_integration_unit.f -----
hw/rtl/imurd_pkg.sv
hw/rtl/imurd_if.sv
hw/rtl/imurd_div.sv
hw/rtl/imurd_datapath.sv
hw/rtl/imurd_ctrl.sv
hw/rtl/imu_rate_derivative_and_integration_unit.sv
hw/rtl/imurd_checker.sv
tb/tb_imu_rate_derivative_and_integration_unit.sv
